/* src/assert_macros.svh */
// assertion macros used by the rtl of the substring search block
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// when cond holds, prop holds on the same edge
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// when cond holds, prop holds on the next edge
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

/* src/fso_pkg.sv */
// types and constants of the first substring occurrence search
// no dependencies; used by every module of the block
package fso_pkg;

    // pattern storage is fixed by the two 64-bit pattern registers
    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W     = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } t_cfg_idx;

    // pattern bytes, byte 0 in the low bits
    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    // input transaction
    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in;

    // result transaction
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             text_too_long;
    } t_out;

    // control handed to every window cell
    typedef struct packed {
        logic             shift;
        logic [LEN_W-1:0] len;
    } t_cell_ctl;

endpackage

/* src/fso_cfg_regs.sv */
// configuration registers: pattern length and the sixteen pattern bytes
// depends on fso_pkg
module fso_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [fso_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [63:0]                   i_data,
    output logic [fso_pkg::LEN_W-1:0]     o_len,
    output fso_pkg::t_pattern             o_pattern
);

    logic [fso_pkg::LEN_W-1:0] r_len;
    logic [63:0]               r_pat_low;
    logic [63:0]               r_pat_high;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_pat_low  <= '0;
            r_pat_high <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                fso_pkg::CFG_PATTERN_LENGTH: r_len      <= i_data[fso_pkg::LEN_W-1:0];
                fso_pkg::CFG_PATTERN_LOW:    r_pat_low  <= i_data;
                fso_pkg::CFG_PATTERN_HIGH:   r_pat_high <= i_data;
                default: ;
            endcase
        end
    end

    assign o_len     = r_len;
    assign o_pattern = {r_pat_high, r_pat_low};

endmodule

/* src/fso_cell.sv */
// one window cell: holds the text byte of a fixed age and compares it
// with the pattern byte that lines up with it; depends on fso_pkg
module fso_cell #(
    parameter int AGE = 1
) (
    input  logic               i_clk,
    input  fso_pkg::t_cell_ctl i_ctl,
    input  fso_pkg::t_pattern  i_pattern,
    input  logic [7:0]         i_byte,
    output logic [7:0]         o_byte,
    output logic               o_eq
);

    localparam logic [fso_pkg::LEN_W-1:0] AGE_V = fso_pkg::LEN_W'(AGE);

    logic [7:0]                r_byte;
    logic [fso_pkg::LEN_W-1:0] w_sel;

    // take the younger neighbor's byte on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // pattern byte for this age is len-1-age; ages beyond the pattern pass
    always_comb begin
        w_sel = i_ctl.len - AGE_V - fso_pkg::LEN_W'(1);
        o_eq  = (i_ctl.len <= AGE_V) || (r_byte == i_pattern[w_sel[3:0]]);
    end

    assign o_byte = r_byte;

endmodule

/* src/first_substring_occurrence.sv */
// top level of the first substring occurrence search: counters, result
// register and the chain of window cells; depends on fso_pkg, fso_cell,
// fso_cfg_regs and assert_macros.svh
//
//  channel | direction | handshake               | payload
//  in      | input     | i_in_valid/o_in_stall   | fso_pkg::t_in
//  out     | output    | o_out_valid/i_out_stall | fso_pkg::t_out
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// one text byte is taken every cycle unless the input is stalled; the window compare across all cells
// finishes in the cycle the byte is taken
// the result of a last byte sits in the output register from the next cycle
// reset is synchronous and active low and clears counters and result state
// input stalls only for a last byte while an earlier result is held stalled
`include "assert_macros.svh"

module first_substring_occurrence #(
    parameter int              PATTERN_MAX = 16,
    parameter longint unsigned TEXT_MAX    = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fso_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fso_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fso_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    localparam longint unsigned CNT_SAT = TEXT_MAX + longint'(PATTERN_MAX);
    localparam int CW = $clog2(CNT_SAT + 1);
    localparam logic [fso_pkg::LEN_W-1:0] PMAX_V = fso_pkg::LEN_W'(PATTERN_MAX);

    logic [fso_pkg::LEN_W-1:0] w_len_reg;
    fso_pkg::t_pattern         w_pattern;
    logic [fso_pkg::LEN_W-1:0] w_len;
    logic [fso_pkg::LEN_W-1:0] w_sel0;
    fso_pkg::t_cell_ctl        w_ctl;
    logic                      w_accept;
    logic                      w_last_accept;
    logic [7:0]                w_win [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]    w_eq;
    logic [CW:0]               w_pos_p1;
    logic [CW:0]               w_start;
    logic                      w_hit;
    logic                      w_ovf;
    fso_pkg::t_out             w_res;

    logic [CW-1:0]             r_count;
    logic                      r_match;
    logic [fso_pkg::POS_W-1:0] r_start;
    logic                      r_ovf;
    logic                      r_out_valid;
    fso_pkg::t_out             r_out;

    // configuration registers, always ready
    fso_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_len     (w_len_reg),
        .o_pattern (w_pattern)
    );
    assign o_cfg_ready = 1'b1;

    // handshake
    assign o_in_stall    = r_out_valid && i_out_stall && i_in_data.last_byte;
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_last_accept = w_accept && i_in_data.last_byte;

    // pattern length clamped to the window size
    assign w_len       = (w_len_reg > PMAX_V) ? PMAX_V : w_len_reg;
    assign w_ctl.shift = w_accept;
    assign w_ctl.len   = w_len;

    // age zero is the incoming byte, compared here
    assign w_win[0] = i_in_data.text_byte;
    assign w_sel0   = w_len - fso_pkg::LEN_W'(1);
    assign w_eq[0]  = (w_len == '0) || (i_in_data.text_byte == w_pattern[w_sel0[3:0]]);

    // chain of window cells, one per older byte
    for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_cell
        fso_cell #(
            .AGE (k)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_pattern (w_pattern),
            .i_byte    (w_win[k-1]),
            .o_byte    (w_win[k]),
            .o_eq      (w_eq[k])
        );
    end

    // candidate start and match decision for this byte
    always_comb begin
        w_pos_p1 = {1'b0, r_count} + (CW+1)'(1);
        w_start  = w_pos_p1 - (CW+1)'(w_len);
        w_hit    = !r_match && (w_len != '0) && (w_pos_p1 >= (CW+1)'(w_len))
                   && (w_start < (CW+1)'(TEXT_MAX)) && (&w_eq);
        w_ovf    = r_ovf || ({1'b0, r_count} >= (CW+1)'(TEXT_MAX));
    end

    // result of a last byte
    always_comb begin
        w_res.text_too_long = w_ovf;
        if (w_len == '0) begin
            w_res.found    = 1'b1;
            w_res.position = '0;
        end else if (r_match) begin
            w_res.found    = 1'b1;
            w_res.position = r_start;
        end else if (w_hit) begin
            w_res.found    = 1'b1;
            w_res.position = fso_pkg::POS_W'(w_start);
        end else begin
            w_res.found    = 1'b0;
            w_res.position = '0;
        end
    end

    // per-text state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_match <= 1'b0;
            r_start <= '0;
            r_ovf   <= 1'b0;
        end else if (w_accept) begin
            if (i_in_data.last_byte) begin
                r_count <= '0;
                r_match <= 1'b0;
                r_start <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (r_count < CW'(CNT_SAT)) begin
                    r_count <= r_count + CW'(1);
                end
                if (w_hit) begin
                    r_match <= 1'b1;
                    r_start <= fso_pkg::POS_W'(w_start);
                end
                r_ovf <= w_ovf;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last_byte) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a last byte always leaves a result behind
    `ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, w_last_accept, r_out_valid)
    // a last byte clears the per-text state
    `ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_last_accept, r_count == '0 && !r_match && !r_ovf)
    // a missing pattern reports position zero
    `ASSERT_SAME(a_miss_pos_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.found, o_out_data.position == '0)
    // byte count never passes its saturation point
    `ASSERT_SAME(a_count_sat, i_clk, i_rst_n, 1'b1, r_count <= CW'(CNT_SAT))

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// self-checking testbench of first_substring_occurrence: streams texts against a series
// of patterns and checks each search result against an in-bench model of the search
// depends on fso_pkg and the first_substring_occurrence rtl
module tb;

    localparam int unsigned TEXT_LIMIT   = 65536;
    localparam int          RANDOM_ITEMS = 1550;
    localparam int          PHASE_ITEMS  = 130;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          IDLE_LIMIT   = 20000;
    localparam int          REPORT_LIMIT = 10;
    localparam logic [fso_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // clock, reset and channel signals
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    fso_pkg::t_in                  in_data   = '0;
    logic                          out_stall = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [fso_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]                   cfg_data  = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    fso_pkg::t_out                 o_out_data;
    logic                          o_cfg_ready;

    // search model: register copies and per-text state
    logic [fso_pkg::LEN_W-1:0] cfg_length = '0;
    logic [63:0]               cfg_low    = '0;
    logic [63:0]               cfg_high   = '0;
    logic [7:0]                window_bytes [fso_pkg::PAT_BYTES-1];
    int unsigned               seen_count;
    bit                        hit_seen;
    int unsigned               hit_start;
    bit                        overflowed;

    // stimulus and expected results
    fso_pkg::t_in  text_items[$];
    fso_pkg::t_out expected_results[$];
    logic [7:0]    text_buf[$];
    fso_pkg::t_out next_expected;
    int            send_gap_pct = 0;
    int            stall_pct    = 0;
    int            fail_count   = 0;
    int            idle_cycles  = 0;

    first_substring_occurrence u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] pattern_byte(int j);
        return (j < 8) ? cfg_low[j*8 +: 8] : cfg_high[(j-8)*8 +: 8];
    endfunction

    function automatic void clear_text();
        int i;
        for (i = 0; i < fso_pkg::PAT_BYTES - 1; i++) window_bytes[i] = 8'h00;
        seen_count = 0;
        hit_seen   = 1'b0;
        hit_start  = 0;
        overflowed = 1'b0;
    endfunction

    // one text byte through the search model, queues a result on a last byte
    function automatic void search_step(fso_pkg::t_in item);
        int unsigned   m;
        int unsigned   pos;
        int unsigned   start;
        int unsigned   age;
        int            j;
        bit            equal;
        logic [7:0]    t;
        fso_pkg::t_out res;
        m   = (cfg_length > fso_pkg::PAT_BYTES) ? fso_pkg::PAT_BYTES : cfg_length;
        pos = seen_count;
        if (pos >= TEXT_LIMIT) overflowed = 1'b1;
        if (!hit_seen && m > 0 && pos + 1 >= m) begin
            start = pos + 1 - m;
            if (start < TEXT_LIMIT) begin
                equal = 1'b1;
                for (j = 0; j < m; j++) begin
                    age = m - 1 - j;
                    t = (age == 0) ? item.text_byte : window_bytes[age-1];
                    if (t != pattern_byte(j)) equal = 1'b0;
                end
                if (equal) begin
                    hit_seen  = 1'b1;
                    hit_start = start;
                end
            end
        end
        for (j = fso_pkg::PAT_BYTES - 2; j > 0; j--) window_bytes[j] = window_bytes[j-1];
        window_bytes[0] = item.text_byte;
        if (seen_count < TEXT_LIMIT + fso_pkg::PAT_BYTES) seen_count++;
        if (item.last_byte) begin
            if (m == 0) begin
                res.found    = 1'b1;
                res.position = '0;
            end else if (hit_seen) begin
                res.found    = 1'b1;
                res.position = hit_start[fso_pkg::POS_W-1:0];
            end else begin
                res.found    = 1'b0;
                res.position = '0;
            end
            res.text_too_long = overflowed;
            expected_results.push_back(res);
            clear_text();
        end
    endfunction

    // input driver: one text byte per transaction from the pending queue
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) search_step(in_data);
            if (!in_valid || !o_in_stall) begin
                if (text_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= text_items.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and random receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result: found=%0b position=%0d too_long=%0b",
                                 o_out_data.found, o_out_data.position,
                                 o_out_data.text_too_long);
                end else begin
                    next_expected = expected_results.pop_front();
                    if (o_out_data.found !== next_expected.found ||
                        o_out_data.position !== next_expected.position ||
                        o_out_data.text_too_long !== next_expected.text_too_long) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("mismatch found/pos/long: exp %0b/%0d/%0b got %0b/%0d/%0b",
                                     next_expected.found, next_expected.position,
                                     next_expected.text_too_long,
                                     o_out_data.found, o_out_data.position,
                                     o_out_data.text_too_long);
                    end
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // cycles without any transaction on any channel
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) ||
            (cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("first_substring_occurrence regression: fail");
        $finish;
    end

    task automatic write_reg(input logic [fso_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        case (idx)
            fso_pkg::CFG_PATTERN_LENGTH: cfg_length = data[fso_pkg::LEN_W-1:0];
            fso_pkg::CFG_PATTERN_LOW:    cfg_low    = data;
            fso_pkg::CFG_PATTERN_HIGH:   cfg_high   = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 47; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 47; end
            default: begin send_gap_pct = 38; stall_pct = 38; end
        endcase
    endtask

    // sender holds off until every result is back and the block has settled
    task automatic drain_results();
        while (text_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // move the text buffer to the pending queue, last flag on its final byte
    task automatic commit_text();
        fso_pkg::t_in item;
        int           i;
        for (i = 0; i < text_buf.size(); i++) begin
            item.text_byte = text_buf[i];
            item.last_byte = (i == text_buf.size() - 1);
            text_items.push_back(item);
        end
        text_buf.delete();
    endtask

    // random pattern and length, extremes included
    task automatic configure_random();
        logic [fso_pkg::LEN_W-1:0] len;
        logic [63:0]               upper;
        fso_pkg::t_pattern         pat;
        logic [7:0]                base;
        int                        i;
        case ($urandom_range(9))
            0:       len = '0;
            1:       len = fso_pkg::LEN_W'(fso_pkg::PAT_BYTES);
            2:       len = fso_pkg::LEN_W'($urandom_range(31, fso_pkg::PAT_BYTES + 1));
            3:       len = fso_pkg::LEN_W'(1);
            default: len = fso_pkg::LEN_W'($urandom_range(fso_pkg::PAT_BYTES, 1));
        endcase
        base = 8'($urandom);
        for (i = 0; i < fso_pkg::PAT_BYTES; i++)
            pat[i] = ($urandom_range(3) == 0) ? 8'($urandom) : 8'(base + $urandom_range(3));
        case ($urandom_range(7))
            0:       pat = '1;
            1:       pat = '0;
            default: ;
        endcase
        upper = {$urandom, $urandom};
        write_reg(fso_pkg::CFG_PATTERN_LENGTH, {upper[63:fso_pkg::LEN_W], len});
        write_reg(fso_pkg::CFG_PATTERN_LOW, pat[7:0]);
        write_reg(fso_pkg::CFG_PATTERN_HIGH, pat[15:8]);
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    endtask

    // mostly texts built around the pattern, some plain noise
    task automatic build_random_text();
        int unsigned eff;
        int          n;
        int          kind;
        int          at;
        int          i;
        int          copies;
        eff  = (cfg_length > fso_pkg::PAT_BYTES) ? fso_pkg::PAT_BYTES : cfg_length;
        kind = $urandom_range(99);
        n    = $urandom_range(40, 1);
        if ($urandom_range(9) == 0) n = $urandom_range(eff + 1, 1);
        for (i = 0; i < n; i++) begin
            if (kind < 80 && eff > 0 && $urandom_range(3) != 0)
                text_buf.push_back(pattern_byte($urandom_range(eff - 1)));
            else
                text_buf.push_back(8'($urandom));
        end
        if (kind < 80 && eff > 0 && n >= eff) begin
            copies = $urandom_range(2);
            repeat (copies) begin
                at = $urandom_range(n - eff);
                for (i = 0; i < eff; i++) text_buf[at+i] = pattern_byte(i);
                // broken copy
                if ($urandom_range(3) == 0)
                    text_buf[at + $urandom_range(eff - 1)] ^= 8'(1 << $urandom_range(7));
            end
        end
        commit_text();
    endtask

    initial begin
        int phase;
        int start_size;
        int random_total;
        clear_text();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pattern after reset, single-byte texts
        set_idling(0);
        text_buf = '{8'h00};
        commit_text();
        text_buf = '{8'hff};
        commit_text();
        drain_results();

        // directed: three-byte pattern, exact, too short, earliest of two, absent
        write_reg(fso_pkg::CFG_PATTERN_LENGTH, 64'd3);
        write_reg(fso_pkg::CFG_PATTERN_LOW, 64'hffff_ffff_ff5a_ff00);
        write_reg(fso_pkg::CFG_PATTERN_HIGH, '1);
        write_reg(CFG_UNUSED, 64'd1);
        text_buf = '{8'h00, 8'hff, 8'h5a};
        commit_text();
        text_buf = '{8'h00, 8'hff};
        commit_text();
        text_buf = '{8'h5a, 8'h00, 8'h00, 8'hff, 8'h5a, 8'h00, 8'hff, 8'h5a};
        commit_text();
        text_buf = '{8'h11, 8'h22, 8'h33};
        commit_text();
        drain_results();

        // random phases, each ends with a full drain before the next write
        phase        = 0;
        random_total = 0;
        while (random_total < RANDOM_ITEMS) begin
            set_idling(phase % 4);
            configure_random();
            start_size = text_items.size();
            while (text_items.size() - start_size < PHASE_ITEMS) build_random_text();
            random_total += text_items.size() - start_size;
            drain_results();
            phase++;
        end

        if (fail_count == 0 && expected_results.size() == 0)
            $display("first_substring_occurrence regression: pass");
        else
            $display("first_substring_occurrence regression: fail");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/fso_pkg.sv
src/fso_cfg_regs.sv
src/fso_cell.sv
src/first_substring_occurrence.sv
dv/tb.sv
